[rtl/piddc_pkg.sv]
// Shared types and constants for the positional / incremental PID controller.
// No dependencies; imported by the top level, the integrator and the checker.

package piddc_pkg;

   // Field widths
   localparam int SAMPLE_W   = 16;            // reference, feedback, drive
   localparam int ERR_W      = SAMPLE_W + 1;  // reference - feedback
   localparam int DIFF1_W    = ERR_W + 1;     // e - e1
   localparam int DIFF2_W    = ERR_W + 2;     // e - 2*e1 + e2
   localparam int GAIN_W     = 32;            // signed Q16.16
   localparam int LIMIT_W    = 15;            // clamp magnitudes
   localparam int FRAC_W     = 16;            // fractional bits of the Q formats
   localparam int ACC_W      = 48;            // Q32.16 integral accumulator
   localparam int PROD_P_W   = GAIN_W + DIFF1_W;
   localparam int PROD_I_W   = GAIN_W + ERR_W;
   localparam int PROD_D_W   = GAIN_W + DIFF2_W;
   localparam int PD_W       = PROD_D_W + 1;  // p term + d term
   localparam int SUM_W      = PD_W + 2;      // p + d + integral
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = GAIN_W;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOOP_MODE      = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5
   } csr_index_type;

   // Loop modes
   localparam logic MODE_POSITION = 1'b0;
   localparam logic MODE_DELTA    = 1'b1;

   // Control from the pipeline to the integrator
   typedef struct packed {
      logic load;        // a transfer enters the accumulate stage
      logic clear;       // the item is a clear request
      logic delta_mode;  // incremental mode: overwrite, no clamp
   } integ_ctl_type;

endpackage

[rtl/pid_position_delta_controller.sv]
// PID controller, positional or incremental, four-register pipeline.
// A sample passes through the input, product, accumulate and result registers before rsp_valid rises.
// Throughput: one sample per cycle while rsp_stall is low; the three gain multipliers run in parallel.
// rsp_stall holds the whole pipeline; req_stall rises only when it is full.
// Synchronous reset zeroes the configuration registers, valid flags, error history and the integral.
// Depends on piddc_pkg and piddc_integrator.

module pid_position_delta_controller (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_clear,
   input  logic signed [piddc_pkg::SAMPLE_W-1:0]      req_reference,
   input  logic signed [piddc_pkg::SAMPLE_W-1:0]      req_feedback,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [piddc_pkg::SAMPLE_W-1:0]      rsp_drive,
   input  logic                                       csr_write,
   input  logic        [piddc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic        [piddc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import piddc_pkg::*;

   localparam int Q_W = SUM_W - FRAC_W;

   // Configuration registers
   logic                     mode_ff;
   logic signed [GAIN_W-1:0] gain_p_ff;
   logic signed [GAIN_W-1:0] gain_i_ff;
   logic signed [GAIN_W-1:0] gain_d_ff;
   logic [LIMIT_W-1:0]       out_limit_ff;
   logic [LIMIT_W-1:0]       int_limit_ff;

   // Error history
   logic signed [ERR_W-1:0]  prev_err_ff;
   logic signed [ERR_W-1:0]  prev2_err_ff;

   // Stage 0: input register
   logic                      s0_valid_ff;
   logic                      s0_clear_ff;
   logic signed [ERR_W-1:0]   s0_e_ff;
   logic signed [DIFF1_W-1:0] s0_d1_ff;
   logic signed [DIFF2_W-1:0] s0_d2_ff;
   logic signed [ERR_W-1:0]   e_in;
   logic signed [DIFF1_W-1:0] d1_in;
   logic signed [DIFF2_W-1:0] d2_in;

   // Stage 1: products
   logic                       s1_valid_ff;
   logic                       s1_clear_ff;
   logic signed [PROD_P_W-1:0] s1_p_ff;
   logic signed [PROD_I_W-1:0] s1_i_ff;
   logic signed [PROD_D_W-1:0] s1_d_ff;
   logic signed [DIFF1_W-1:0]  p_opnd;
   logic signed [DIFF2_W-1:0]  d_opnd;

   // Stage 2: integral and p+d
   logic                       s2_valid_ff;
   logic signed [PD_W-1:0]     s2_pd_ff;
   logic signed [ACC_W-1:0]    acc;
   integ_ctl_type              integ_ctl;

   // Stage 3: result register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_drive_ff;
   logic signed [SAMPLE_W-1:0] drive_in;
   logic signed [SUM_W-1:0]    sum;
   logic signed [Q_W-1:0]      quot;
   logic signed [Q_W-1:0]      out_lim;

   // Stage enables: a stage moves when empty or when its successor moves
   logic rsp_en, s2_en, s1_en, s0_en, req_xfer;

   assign rsp_en    = !rsp_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || rsp_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign s0_en     = !s0_valid_ff || s1_en;
   assign req_stall = !s0_en;
   assign req_xfer  = req_valid && s0_en;

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_POSITION;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         out_limit_ff <= '0;
         int_limit_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOOP_MODE:      mode_ff      <= csr_data[0];
            CSR_GAIN_P:         gain_p_ff    <= $signed(csr_data);
            CSR_GAIN_I:         gain_i_ff    <= $signed(csr_data);
            CSR_GAIN_D:         gain_d_ff    <= $signed(csr_data);
            CSR_OUTPUT_LIMIT:   out_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_INTEGRAL_LIMIT: int_limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Error and its differences against the history
   always_comb begin
      e_in  = ERR_W'(req_reference) - ERR_W'(req_feedback);
      d1_in = DIFF1_W'(e_in) - DIFF1_W'(prev_err_ff);
      d2_in = DIFF2_W'(e_in) - (DIFF2_W'(prev_err_ff) <<< 1) + DIFF2_W'(prev2_err_ff);
   end

   // Shift the history on each transfer; clear zeroes it
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff  <= '0;
         prev2_err_ff <= '0;
      end else if (req_xfer) begin
         if (req_clear) begin
            prev_err_ff  <= '0;
            prev2_err_ff <= '0;
         end else begin
            prev_err_ff  <= e_in;
            prev2_err_ff <= prev_err_ff;
         end
      end
   end

   // Stage 0: capture the sample; a clear carries zero terms
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s0_clear_ff <= req_clear;
         s0_e_ff     <= req_clear ? '0 : e_in;
         s0_d1_ff    <= req_clear ? '0 : d1_in;
         s0_d2_ff    <= req_clear ? '0 : d2_in;
      end
   end

   // Stage 1: pick operands per mode and multiply by the gains
   always_comb begin
      if (mode_ff == MODE_DELTA) begin
         p_opnd = s0_d1_ff;
         d_opnd = s0_d2_ff;
      end else begin
         p_opnd = DIFF1_W'(s0_e_ff);
         d_opnd = DIFF2_W'(s0_d1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && s0_valid_ff) begin
         s1_clear_ff <= s0_clear_ff;
         s1_p_ff     <= PROD_P_W'(gain_p_ff) * PROD_P_W'(p_opnd);
         s1_i_ff     <= PROD_I_W'(gain_i_ff) * PROD_I_W'(s0_e_ff);
         s1_d_ff     <= PROD_D_W'(gain_d_ff) * PROD_D_W'(d_opnd);
      end
   end

   // Stage 2: update the integral (accumulate, or overwrite in delta mode), add p and d
   assign integ_ctl.load       = s2_en && s1_valid_ff;
   assign integ_ctl.clear      = s1_clear_ff;
   assign integ_ctl.delta_mode = (mode_ff == MODE_DELTA);

   piddc_integrator u_integrator (
      .clock  (clock),
      .reset  (reset),
      .ctl    (integ_ctl),
      .i_prod (s1_i_ff),
      .limit  (int_limit_ff),
      .acc    (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_pd_ff <= PD_W'(s1_p_ff) + PD_W'(s1_d_ff);
      end
   end

   // Stage 3: total, truncate toward zero, clamp to +-output_limit
   always_comb begin
      sum     = SUM_W'(s2_pd_ff) + SUM_W'(acc);
      quot    = sum[SUM_W-1:FRAC_W]
              + Q_W'({1'b0, (sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0))});
      out_lim = $signed({{(Q_W - LIMIT_W){1'b0}}, out_limit_ff});
      if (quot > out_lim) begin
         drive_in = SAMPLE_W'(out_lim);
      end else if (quot < -out_lim) begin
         drive_in = SAMPLE_W'(-out_lim);
      end else begin
         drive_in = SAMPLE_W'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_en && s2_valid_ff) begin
         rsp_drive_ff <= drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

[rtl/piddc_integrator.sv]
// Integral accumulator of the PID controller (Q32.16), one update per item.
// Depends on piddc_pkg.

module piddc_integrator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  piddc_pkg::integ_ctl_type                ctl,
   input  logic signed [piddc_pkg::PROD_I_W-1:0]   i_prod,
   input  logic        [piddc_pkg::LIMIT_W-1:0]    limit,
   output logic signed [piddc_pkg::ACC_W-1:0]      acc
);
   import piddc_pkg::*;

   localparam int WIDE_W = PROD_I_W + 1;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [WIDE_W-1:0] acc_sum;
   logic signed [WIDE_W-1:0] lim_q;

   // Add the new term and clamp to +-limit in Q.16; a clear zeroes it, delta mode overwrites unclamped
   always_comb begin
      acc_sum = WIDE_W'(acc_ff) + WIDE_W'(i_prod);
      lim_q   = $signed({{(WIDE_W - LIMIT_W - FRAC_W){1'b0}}, limit, {FRAC_W{1'b0}}});
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.delta_mode) begin
         acc_in = ACC_W'(i_prod);
      end else if (acc_sum > lim_q) begin
         acc_in = ACC_W'(lim_q);
      end else if (acc_sum < -lim_q) begin
         acc_in = ACC_W'(-lim_q);
      end else begin
         acc_in = ACC_W'(acc_sum);
      end
   end

   // Update once per item entering the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.load) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

[rtl/piddc_checker.sv]
// Port-level checks for the PID controller, bound to the top level.
// Depends on piddc_pkg and pid_position_delta_controller.

module piddc_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_stall,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic signed [piddc_pkg::SAMPLE_W-1:0]    rsp_drive,
   input logic                                     csr_write,
   input logic        [piddc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic        [piddc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import piddc_pkg::*;

   localparam int DEPTH   = 4;
   localparam int COUNT_W = 3;

   logic               limit_zero_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Track whether the output clamp is zero
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_zero_ff <= 1'b1;
      end else if (csr_write && (csr_index == CSR_OUTPUT_LIMIT)) begin
         limit_zero_ff <= (csr_data[LIMIT_W-1:0] == '0);
      end
   end

   // Count items in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         count_ff <= count_ff + COUNT_W'(1);
      end else if (rsp_xfer && !req_xfer) begin
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled transfer changed");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive != 16'sh8000)
      else $error("drive outside symmetric range");

   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && limit_zero_ff |-> rsp_drive == '0)
      else $error("drive nonzero with zero output limit");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= COUNT_W'(DEPTH)) && (!rsp_valid || (count_ff != '0)))
      else $error("item count out of step with pipeline");

endmodule

bind pid_position_delta_controller piddc_checker u_piddc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_drive (rsp_drive),
   .csr_write (csr_write),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);
